### rtl/srs_pkg.sv
package srs_pkg;

  localparam int NumSectorsDef = 16;
  localparam int CountWidthDef = 16;

  localparam int CfgW      = 5;
  localparam int SectorW   = 4;
  localparam int OutCountW = 16;
  localparam int TotalW    = 20;

  // Operation codes carried in the input item
  localparam logic OpInsert  = 1'b0;
  localparam logic OpExtract = 1'b1;

  // Register index (paddr[2])
  localparam logic RegSectorsInUse = 1'b0;

  typedef struct packed {
    logic start;   // latch item, clear scan state
    logic issue;   // read counter at scan index, advance
    logic load;    // commit update, load output register
  } srs_cmd_t;

  typedef struct packed {
    logic scan_last;  // current read is the last active sector
    logic out_free;   // output register can take a new result
  } srs_stat_t;

endpackage

### rtl/srs_ctrl.sv
module srs_ctrl
  import srs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  srs_stat_t stat_i,
  output srs_cmd_t  cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        cmd_o.issue = 1'b1;
        if (stat_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StDone;
      end
      StDone: begin
        // hold until the output register is free
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/srs_dp.sv
module srs_dp
  import srs_pkg::*;
#(
  parameter int NUM_SECTORS = NumSectorsDef,
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CfgW-1:0]      cfg_i,
  input  logic                 op_i,
  input  logic [SectorW-1:0]   sector_i,
  input  srs_cmd_t             cmd_i,
  output srs_stat_t            stat_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 served_valid_o,
  output logic [SectorW-1:0]   served_sector_o,
  output logic                 sector_in_range_o,
  output logic [OutCountW-1:0] sector_count_o,
  output logic [TotalW-1:0]    total_pending_o
);

  localparam int IdxW = $clog2(NUM_SECTORS);
  localparam int NW   = $clog2(NUM_SECTORS + 1);
  localparam int SumW = COUNT_WIDTH + IdxW;

  // counter memory; entries never written read as their reset value
  logic [COUNT_WIDTH-1:0] mem [NUM_SECTORS];
  logic [NUM_SECTORS-1:0] vld_q;

  logic                   op_q, in_range_q;
  logic [SectorW-1:0]     sec_q;
  logic [NW-1:0]          n_q, n_d;
  logic [IdxW-1:0]        idx_q, rd_idx_q, sel_q;
  logic                   acc_q, rd_vld_q, rd_zero_q;
  logic [COUNT_WIDTH-1:0] rdata_q, rd_val;
  logic [SumW-1:0]        sum_q;
  logic                   fwd_found_q, bwd_found_q;
  logic [IdxW-1:0]        fwd_q, bwd_q;
  logic [COUNT_WIDTH-1:0] fwd_val_q, bwd_val_q, cnt_q;

  logic                   hit, inc, sec_match, wr_en;
  logic [IdxW-1:0]        tgt, wr_addr;
  logic [COUNT_WIDTH-1:0] tval, wr_data, res_cnt;
  logic [SumW-1:0]        res_sum;

  always_comb begin
    if (cfg_i == '0) begin
      n_d = NW'(1);
    end else if (32'(cfg_i) > 32'(NUM_SECTORS)) begin
      n_d = NW'(NUM_SECTORS);
    end else begin
      n_d = NW'(cfg_i);
    end
  end

  assign stat_o.scan_last = (NW'(idx_q) == n_q - NW'(1));
  assign stat_o.out_free  = !out_valid_o || out_ready_i;

  assign rd_val = rd_vld_q ? rdata_q : (rd_zero_q ? COUNT_WIDTH'(1) : '0);

  always_comb begin
    hit       = fwd_found_q || bwd_found_q;
    tgt       = fwd_found_q ? fwd_q : bwd_q;
    tval      = fwd_found_q ? fwd_val_q : bwd_val_q;
    inc       = (op_q == OpInsert) && in_range_q && (cnt_q != '1);
    sec_match = (32'(tgt) == 32'(sec_q));
    wr_en     = cmd_i.load && (inc || ((op_q == OpExtract) && hit));
    if (op_q == OpInsert) begin
      wr_addr = IdxW'(sec_q);
      wr_data = cnt_q + COUNT_WIDTH'(1);
      res_cnt = inc ? cnt_q + COUNT_WIDTH'(1) : cnt_q;
      res_sum = sum_q + SumW'(inc);
    end else begin
      wr_addr = tgt;
      wr_data = tval - COUNT_WIDTH'(1);
      res_cnt = (hit && sec_match) ? cnt_q - COUNT_WIDTH'(1) : cnt_q;
      res_sum = sum_q - SumW'(hit);
    end
    if (!in_range_q) begin
      res_cnt = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.issue) begin
      rdata_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      op_q        <= OpInsert;
      in_range_q  <= 1'b0;
      sec_q       <= '0;
      n_q         <= NW'(1);
      idx_q       <= '0;
      rd_idx_q    <= '0;
      sel_q       <= '0;
      acc_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_zero_q   <= 1'b0;
      sum_q       <= '0;
      fwd_found_q <= 1'b0;
      bwd_found_q <= 1'b0;
      fwd_q       <= '0;
      bwd_q       <= '0;
      fwd_val_q   <= '0;
      bwd_val_q   <= '0;
      cnt_q       <= '0;
    end else begin
      acc_q <= cmd_i.issue;
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.load && (op_q == OpExtract) && hit) begin
        sel_q <= tgt;
      end
      if (cmd_i.start) begin
        op_q        <= op_i;
        sec_q       <= sector_i;
        n_q         <= n_d;
        in_range_q  <= (32'(sector_i) < 32'(n_d));
        idx_q       <= '0;
        sum_q       <= '0;
        fwd_found_q <= 1'b0;
        bwd_found_q <= 1'b0;
        cnt_q       <= '0;
      end
      if (cmd_i.issue) begin
        idx_q     <= idx_q + IdxW'(1);
        rd_idx_q  <= idx_q;
        rd_vld_q  <= vld_q[idx_q];
        rd_zero_q <= (idx_q == '0);
      end
      if (acc_q) begin
        sum_q <= sum_q + SumW'(rd_val);
        // forward hit: first nonzero at or after the selector
        if ((rd_val != '0) && (rd_idx_q >= sel_q) && !fwd_found_q) begin
          fwd_found_q <= 1'b1;
          fwd_q       <= rd_idx_q;
          fwd_val_q   <= rd_val;
        end
        // backward hit: last nonzero below the selector
        if ((rd_val != '0) && (rd_idx_q < sel_q)) begin
          bwd_found_q <= 1'b1;
          bwd_q       <= rd_idx_q;
          bwd_val_q   <= rd_val;
        end
        if (32'(rd_idx_q) == 32'(sec_q)) begin
          cnt_q <= rd_val;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      served_valid_o    <= (op_q == OpExtract) && hit;
      served_sector_o   <= ((op_q == OpExtract) && hit) ? SectorW'(tgt) : '0;
      sector_in_range_o <= in_range_q;
      sector_count_o    <= OutCountW'(res_cnt);
      total_pending_o   <= TotalW'(res_sum);
    end
  end

endmodule

### rtl/sector_request_selector_core.sv
// Each item scans the n active counters (n = active sectors) through the single read
// port of the counter memory; a new item is accepted only after the previous one has
// been loaded into the output register.
// A finished result waits in the output register while the next item scans.
// Reset (rst_ni, async low): sector 0 holds one request, others zero,
// selector at 0, sectors_in_use = 1.
module sector_request_selector_core
  import srs_pkg::*;
#(
  parameter int NUM_SECTORS = NumSectorsDef,
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] operation, [4:1] sector, [7:5] zero
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] served_valid, [4:1] served_sector, [5] sector_in_range,
  // [21:6] sector_count, [41:22] total_pending, [47:42] zero
  output logic [47:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CfgW-1:0]      cfg_q;
  srs_cmd_t             cmd;
  srs_stat_t            stat;
  logic                 served_valid, sector_in_range;
  logic [SectorW-1:0]   served_sector;
  logic [OutCountW-1:0] sector_count;
  logic [TotalW-1:0]    total_pending;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegSectorsInUse) ? 32'(cfg_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgW'(1);
    end else if (psel && penable && pwrite && (paddr[2] == RegSectorsInUse)) begin
      cfg_q <= pwdata[CfgW-1:0];
    end
  end

  srs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  srs_dp #(
    .NUM_SECTORS (NUM_SECTORS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .op_i              (s_axis_tdata[0]),
    .sector_i          (s_axis_tdata[4:1]),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .served_valid_o    (served_valid),
    .served_sector_o   (served_sector),
    .sector_in_range_o (sector_in_range),
    .sector_count_o    (sector_count),
    .total_pending_o   (total_pending)
  );

  assign m_axis_tdata = {6'b0, total_pending, sector_count, sector_in_range,
                         served_sector, served_valid};

endmodule

### sim/sector_request_selector_core_test.sv
`timescale 1ns / 100ps

module sector_request_selector_core_test;
  import srs_pkg::*;

  localparam int CycleLimit = 200_000;
  localparam int MaxReports = 100;

  // Packed so that the struct lines up with m_axis_tdata[41:0]
  typedef struct packed {
    logic [19:0] total_pending;
    logic [15:0] sector_count;
    logic        sector_in_range;
    logic [3:0]  served_sector;
    logic        served_valid;
  } selector_result_t;

  class selector_scoreboard;
    logic [15:0]      counts [16];
    logic [3:0]       selector;
    logic [4:0]       sectors_in_use;
    selector_result_t due_results [$];
    int               errors;
    int               checked;
    int               served;

    function new();
      foreach (counts[k]) counts[k] = '0;
      counts[0] = 16'd1;
      selector = '0;
      sectors_in_use = 5'd1;
      errors = 0;
      checked = 0;
      served = 0;
    endfunction

    function int active_sectors();
      if (sectors_in_use == 0) return 1;
      if (sectors_in_use > 16) return 16;
      return int'(sectors_in_use);
    endfunction

    function void write_reg(int index, logic [31:0] value);
      if (index == int'(RegSectorsInUse)) sectors_in_use = value[4:0];
    endfunction

    // Predict the result of one accepted item and queue it
    function void note_item(logic op, logic [3:0] sec);
      int n;
      int found;
      int start;
      int sum;
      selector_result_t r;
      n = active_sectors();
      r = '0;
      found = -1;
      sum = 0;
      r.sector_in_range = (int'(sec) < n);
      if (op == OpInsert) begin
        if (r.sector_in_range && counts[sec] != '1) counts[sec] = counts[sec] + 1'b1;
      end else begin
        if (int'(selector) < n && counts[selector] != 0) begin
          found = int'(selector);
        end else begin
          for (int i = int'(selector) + 1; i < n && found < 0; i++) begin
            if (counts[i] != 0) found = i;
          end
          // a selector outside the active range searches back from the top
          start = (int'(selector) < n) ? int'(selector) : n;
          for (int i = start - 1; i >= 0 && found < 0; i--) begin
            if (counts[i] != 0) found = i;
          end
        end
        if (found >= 0) begin
          counts[found] = counts[found] - 1'b1;
          selector = 4'(found);
          r.served_valid = 1'b1;
          r.served_sector = 4'(found);
        end
      end
      for (int i = 0; i < n; i++) sum += int'(counts[i]);
      r.sector_count = r.sector_in_range ? counts[sec] : '0;
      r.total_pending = 20'(sum);
      due_results.push_back(r);
    endfunction

    function void report(string field, int want, int got);
      errors++;
      if (errors <= MaxReports) $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_result(logic [47:0] data);
      selector_result_t got;
      selector_result_t want;
      got = data[41:0];
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports) $error("result with nothing expected: %h", data);
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (want.served_valid) served++;
      if (got.served_valid !== want.served_valid)
        report("served_valid", want.served_valid, got.served_valid);
      if (got.served_sector !== want.served_sector)
        report("served_sector", want.served_sector, got.served_sector);
      if (got.sector_in_range !== want.sector_in_range)
        report("sector_in_range", want.sector_in_range, got.sector_in_range);
      if (got.sector_count !== want.sector_count)
        report("sector_count", want.sector_count, got.sector_count);
      if (got.total_pending !== want.total_pending)
        report("total_pending", want.total_pending, got.total_pending);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  selector_scoreboard sb = new();
  bit no_gaps = 1'b0;
  int cycles = 0;
  int items_sent = 0;
  int settings_written = 0;

  sector_request_selector_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: check accepted items, stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 19);
    end
  end

  task automatic send_item(input logic op, input logic [3:0] sec);
    while (!no_gaps && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, sec, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(op, sec);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input int index, input logic [4:0] value);
    logic [31:0] word;
    word = {27'($urandom()), value};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(index * 4);
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(index, word);
    settings_written++;
  endtask

  task automatic random_items(input int count, input int insert_pct);
    for (int k = 0; k < count; k++) begin
      send_item(($urandom_range(99) < insert_pct) ? OpInsert : OpExtract,
                4'($urandom_range(15)));
    end
    drain();
  endtask

  initial begin
    logic [4:0] phase_setting [6];
    phase_setting = '{5'd16, 5'd2, 5'd9, 5'd31, 5'd1, 5'd0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state: sector 0 holds the only request, one sector active
    send_item(OpExtract, 4'd0);
    send_item(OpExtract, 4'd0);
    send_item(OpInsert, 4'd0);
    send_item(OpInsert, 4'd15);
    send_item(OpInsert, 4'd1);
    drain();
    // write to an unused register index must leave the sector limit alone
    write_reg(1, 5'd16);
    send_item(OpInsert, 4'd3);
    drain();
    write_reg(0, 5'd16);
    send_item(OpInsert, 4'd15);
    send_item(OpInsert, 4'd7);
    send_item(OpInsert, 4'd7);
    send_item(OpExtract, 4'd9);
    send_item(OpExtract, 4'd0);
    send_item(OpExtract, 4'd15);
    send_item(OpExtract, 4'd4);
    drain();
    // zero active sectors acts as one; selector is left outside the range
    write_reg(0, 5'd0);
    send_item(OpInsert, 4'd5);
    send_item(OpExtract, 4'd0);
    send_item(OpInsert, 4'd0);
    drain();
    write_reg(0, 5'd31);
    send_item(OpExtract, 4'd15);
    send_item(OpExtract, 4'd7);
    drain();
    write_reg(0, 5'd4);
    send_item(OpExtract, 4'd3);
    send_item(OpInsert, 4'd2);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(0, (p == 2) ? 5'($urandom_range(31)) : phase_setting[p]);
      no_gaps = (p == 3);
      random_items(70, (p % 2 == 0) ? 60 : 45);
    end

    write_reg(0, 5'd16);
    no_gaps = 1'b0;
    random_items(20, 50);

    repeat (40) @(posedge clk_i);
    $display("Ran %0d items over %0d register writes, sector limits from zero past the top.",
             items_sent, settings_written);
    $display("Checked %0d results, %0d of them served extracts.", sb.checked, sb.served);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
